>>> rtl/pva_pkg.sv
// Shared types, codes and the key code function for the polyphonic voice allocator.
// Depends on nothing; the allocator, the sequencer and the testbench import it.
`default_nettype none

package pva_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_CONTROL  = 2'd2,
        REQ_UNUSED   = 2'd3
    } pva_req_t;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_KEY_OFF = 2'd0,
        ACT_RETRIG  = 2'd1,
        ACT_STEAL   = 2'd2,
        ACT_KEY_ON  = 2'd3
    } pva_action_t;

    // Sustain pedal controller number.
    localparam logic [6:0] CTL_SUSTAIN = 7'd64;

    // Semitone position within an octave, as the chip nibble.
    localparam logic [3:0] SEMITONE_NIBBLE [0:11] = '{
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14
    };

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] note_or_control;
        logic [6:0] velocity_or_value;
    } pva_in_t;

    typedef struct packed {
        pva_action_t action;
        logic [2:0]  voice_index;
        logic [6:0]  key_code;
        logic        last;
    } pva_out_t;

    // Result word handed from the sequencer to the output register.
    typedef struct packed {
        logic     valid;
        pva_out_t word;
    } pva_push_t;

    // Key code of a note shifted by a signed semitone offset. The division by 12
    // is a multiply by 43 and a shift, exact for every value below 128.
    function automatic logic [6:0] pva_key_code(input logic [6:0] note,
                                                input logic [6:0] shift);
        logic signed [8:0] t;
        logic [6:0]        n;
        logic [12:0]       prod;
        logic [3:0]        q;
        logic [6:0]        q12;
        logic [3:0]        r;
        logic [2:0]        oct;
        begin
            t = $signed({2'b00, note}) + $signed({{2{shift[6]}}, shift});
            if (t <= 9'sd1) begin
                n = 7'd0;
            end else if (t >= 9'sd127) begin
                n = 7'd126;
            end else begin
                n = 7'(t[6:0] - 7'd1);
            end
            prod = 13'(n) * 13'd43;
            q    = prod[12:9];
            q12  = 7'({q, 3'b000} + {1'b0, q, 2'b00});
            r    = 4'(n - q12);
            if (q == 4'd0) begin
                oct = 3'd0;
            end else if (q >= 4'd9) begin
                oct = 3'd7;
            end else begin
                oct = 3'(q - 4'd1);
            end
            return {oct, SEMITONE_NIBBLE[r]};
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/poly_voice_allocator.sv
// An accepted note on or note off is read out of the voice table one voice at a time
// (read, then evaluate and write back); a retrigger ends a note on's scan early, and a
// result the output cannot take yet stalls it. A note on then writes its key-on entry;
// every item ends by handing on its pending final result, if any. Lifting the sustain
// pedal also scans; no new word is taken until the current one is done.
// Reset (aresetn, synchronous, active low) clears all voices at once via valid bits.
`default_nettype none

module poly_voice_allocator #(
    parameter int VOICES   = 8,
    parameter int AGE_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pva_pkg::pva_in_t  s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pva_pkg::pva_out_t      m_word,
    input  wire logic              cfg_wr_en,
    input  wire logic [6:0]        cfg_wr_data
);
    import pva_pkg::*;

    // Transpose register, a signed semitone offset applied when the key code is formed.
    logic [6:0] transpose_reg, transpose_next;

    // Output register. The sequencer keeps one result pending internally, so it can
    // keep scanning while this register still waits for the consumer.
    logic       m_valid_reg, m_valid_next;
    pva_out_t   m_word_reg, m_word_next;

    logic       out_free;
    pva_push_t  push;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    pva_seq #(
        .VOICES   (VOICES),
        .AGE_BITS (AGE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .transpose (transpose_reg),
        .out_free  (out_free),
        .push      (push)
    );

    always_comb begin
        transpose_next = cfg_wr_en ? cfg_wr_data : transpose_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        if (push.valid) begin
            m_valid_next = 1'b1;
            m_word_next  = push.word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_reg <= 7'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            transpose_reg <= transpose_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

endmodule

`default_nettype wire

>>> rtl/pva_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the voice table of the allocator.
`default_nettype none

module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pva_seq.sv
// Voice table sequencer: scans the voice RAM, updates entries and produces result words.
// Depends on pva_pkg and pva_ram.
`default_nettype none

module pva_seq #(
    parameter int VOICES   = 8,
    parameter int AGE_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pva_pkg::pva_in_t   s_word,
    input  wire logic [6:0]         transpose,
    input  wire logic               out_free,
    output pva_pkg::pva_push_t      push
);
    import pva_pkg::*;

    localparam int VW     = $clog2(VOICES);
    localparam int EW     = AGE_BITS + 9;
    localparam int ACT_B  = EW - 1;
    localparam int HELD_B = EW - 2;
    localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_EVAL   = 5'b00100,
        S_KEYON  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        OP_OFF,
        OP_ON,
        OP_RELEASE
    } op_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [6:0]            note_reg, note_next;
    logic [VW-1:0]         idx_reg, idx_next;
    logic [VW-1:0]         voice_reg, voice_next;
    logic                  pedal_reg, pedal_next;
    logic [AGE_BITS-1:0]   age_reg, age_next;
    logic [VOICES-1:0]     valid_reg, valid_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  free_found_reg, free_found_next;
    logic [VW-1:0]         free_idx_reg, free_idx_next;
    logic [AGE_BITS-1:0]   best_reg, best_next;
    logic [VW-1:0]         best_idx_reg, best_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    pva_out_t              pend_word_reg, pend_word_next;

    logic                  ram_wr_en;
    logic [VW-1:0]         ram_wr_addr;
    logic [EW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [EW-1:0]         ram_rd_data;

    logic                  e_active;
    logic                  e_held;
    logic [6:0]            e_note;
    logic [AGE_BITS-1:0]   e_stamp;
    logic [AGE_BITS-1:0]   e_dist;
    logic                  e_hit;
    logic                  want;
    logic                  stall;
    logic                  done;
    pva_out_t              res;
    logic                  take;

    function automatic pva_out_t make_word(input pva_action_t a, input logic [VW-1:0] v,
                                           input logic [6:0] kc);
        logic [VW+2:0] ext;
        pva_out_t      w;
        begin
            ext           = {3'b000, v};
            w.action      = a;
            w.voice_index = ext[2:0];
            w.key_code    = kc;
            w.last        = 1'b0;
            return w;
        end
    endfunction

    pva_ram #(
        .WIDTH (EW),
        .DEPTH (VOICES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // An entry never written since reset reads as inactive, not held and with a zero stamp.
    assign e_active = rd_vld_reg & ram_rd_data[ACT_B];
    assign e_held   = rd_vld_reg & ram_rd_data[HELD_B];
    assign e_note   = ram_rd_data[AGE_BITS+6:AGE_BITS];
    assign e_stamp  = rd_vld_reg ? ram_rd_data[AGE_BITS-1:0] : '0;
    assign e_dist   = age_reg - e_stamp;
    assign e_hit    = e_active && (e_note == note_reg);

    assign s_ready   = (state_reg == S_IDLE);
    assign take      = s_valid && s_ready;
    assign ram_rd_en = (state_reg == S_READ);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        note_next       = note_reg;
        idx_next        = idx_reg;
        voice_next      = voice_reg;
        pedal_next      = pedal_reg;
        age_next        = age_reg;
        valid_next      = valid_reg;
        rd_vld_next     = rd_vld_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;
        want            = 1'b0;
        stall           = 1'b0;
        done            = 1'b0;
        res             = make_word(ACT_KEY_OFF, idx_reg, 7'd0);
        push.valid      = 1'b0;
        push.word       = pend_word_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    note_next       = s_word.note_or_control;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    if (s_word.req_type == REQ_NOTE_ON && s_word.velocity_or_value != 7'd0) begin
                        op_next    = OP_ON;
                        state_next = S_READ;
                    end else if (s_word.req_type == REQ_NOTE_ON ||
                                 s_word.req_type == REQ_NOTE_OFF) begin
                        op_next    = OP_OFF;
                        state_next = S_READ;
                    end else if (s_word.req_type == REQ_CONTROL &&
                                 s_word.note_or_control == CTL_SUSTAIN) begin
                        pedal_next = s_word.velocity_or_value[6];
                        if (pedal_reg && !s_word.velocity_or_value[6]) begin
                            op_next    = OP_RELEASE;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                rd_vld_next = valid_reg[idx_reg];
                state_next  = S_EVAL;
            end
            S_EVAL: begin
                done = (idx_reg == LAST_IDX);
                unique case (op_reg)
                    OP_OFF: begin
                        if (e_hit) begin
                            if (pedal_reg) begin
                                ram_wr_data[HELD_B] = 1'b1;
                            end else begin
                                ram_wr_data[ACT_B]  = 1'b0;
                                ram_wr_data[HELD_B] = 1'b0;
                                want                = 1'b1;
                            end
                        end
                    end
                    OP_RELEASE: begin
                        if (e_active && e_held) begin
                            ram_wr_data[ACT_B]  = 1'b0;
                            ram_wr_data[HELD_B] = 1'b0;
                            want                = 1'b1;
                        end
                    end
                    OP_ON: begin
                        if (!e_active && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if (idx_reg == '0 || e_dist > best_reg) begin
                            best_next     = e_dist;
                            best_idx_next = idx_reg;
                        end
                        if (e_hit) begin
                            done       = 1'b1;
                            want       = 1'b1;
                            res        = make_word(ACT_RETRIG, idx_reg, 7'd0);
                            voice_next = idx_reg;
                            age_next   = age_reg + AGE_BITS'(1);
                        end else if (done) begin
                            voice_next = free_found_next ? free_idx_next : best_idx_next;
                            if (!free_found_next) begin
                                want = 1'b1;
                                res  = make_word(ACT_STEAL, voice_next, 7'd0);
                            end
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
                stall = want && pend_valid_reg && !out_free;
                if (stall) begin
                    state_next      = state_reg;
                    free_found_next = free_found_reg;
                    free_idx_next   = free_idx_reg;
                    best_next       = best_reg;
                    best_idx_next   = best_idx_reg;
                    voice_next      = voice_reg;
                    age_next        = age_reg;
                end else begin
                    ram_wr_en = (op_reg == OP_OFF) ? e_hit :
                                (op_reg == OP_RELEASE) ? want : 1'b0;
                    if (want) begin
                        push.valid      = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_word_next  = res;
                    end
                    if (done) begin
                        state_next = (op_reg == OP_ON) ? S_KEYON : S_FINISH;
                    end else begin
                        idx_next   = idx_reg + VW'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_KEYON: begin
                if (!(pend_valid_reg && !out_free)) begin
                    push.valid            = pend_valid_reg;
                    pend_valid_next       = 1'b1;
                    pend_word_next        = make_word(ACT_KEY_ON, voice_reg,
                                                      pva_key_code(note_reg, transpose));
                    ram_wr_en             = 1'b1;
                    ram_wr_addr           = voice_reg;
                    ram_wr_data           = {1'b1, 1'b0, note_reg, age_reg};
                    valid_next[voice_reg] = 1'b1;
                    age_next              = age_reg + AGE_BITS'(1);
                    state_next            = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push.valid      = 1'b1;
                    push.word.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pedal_reg      <= 1'b0;
            age_reg        <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pedal_reg      <= pedal_next;
            age_reg        <= age_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        note_reg       <= note_next;
        idx_reg        <= idx_next;
        voice_reg      <= voice_next;
        rd_vld_reg     <= rd_vld_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        pend_word_reg  <= pend_word_next;
    end

    // A word is only handed over when the output register can take it.
    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> out_free)
        else $error("result word pushed into a full output register");

    // The sequencer never reads and writes the table in the same cycle.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("voice table read and written in the same cycle");

    // The final word of an item returns the sequencer to idle.
    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && push.word.last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after the final word of an item");

    // The age counter moves only on a retrigger or a key on.
    a_age_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_KEYON && state_reg != S_EVAL) |=> $stable(age_reg))
        else $error("age counter changed outside of a note on");

endmodule

`default_nettype wire

>>> dv/poly_voice_allocator_test.sv
// Self-checking testbench for poly_voice_allocator: directed and random MIDI words with an
// in-bench voice allocation predictor. Depends on rtl/pva_pkg.sv and the block's RTL.
`timescale 1ns / 100ps

module poly_voice_allocator_test;

    import pva_pkg::*;

    localparam int VOICES        = 8;
    localparam int AGE_BITS      = 32;
    // Extra wait for the block to finish a word that owes no result, with margin for the tail.
    localparam int SETTLE_CYCLES = 3 * VOICES + 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 75;
    localparam int PRESSURE_WORDS = 40;

    // Chip semitone nibble for each position inside an octave.
    localparam logic [3:0] NIBBLE_OF_SEMITONE [12] = '{
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14
    };

    // Receiver behavior, changed at random whenever the current mode runs out.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_MASK
    } rx_mode_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    pva_in_t    s_word      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    pva_out_t   m_word;
    logic       cfg_wr_en   = 1'b0;
    logic [6:0] cfg_wr_data = '0;

    // Predictor copy of the voice table.
    logic              voice_on        [VOICES];
    logic              voice_sustained [VOICES];
    logic [6:0]        voice_note      [VOICES];
    logic [AGE_BITS-1:0] voice_stamp   [VOICES];
    logic [AGE_BITS-1:0] age_now;
    logic              pedal_is_down;
    logic signed [6:0] transpose_setting;

    // Actions produced by the word being predicted, then the ones still owed by the block.
    pva_out_t batch_actions[$];
    pva_out_t voice_actions_due[$];

    int unsigned bad_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_asks    = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left    = 0;
    int unsigned burst_left   = 0;
    bit          sender_eager = 1'b0;
    int          note_base    = 48;

    poly_voice_allocator #(
        .VOICES   (VOICES),
        .AGE_BITS (AGE_BITS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: the slowest legal run is far below this limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    function automatic void reset_voice_table();
        for (int i = 0; i < VOICES; i++) begin
            voice_on[i]        = 1'b0;
            voice_sustained[i] = 1'b0;
            voice_note[i]      = '0;
            voice_stamp[i]     = '0;
        end
        age_now           = '0;
        pedal_is_down     = 1'b0;
        transpose_setting = '0;
    endfunction

    // Key code of a played note under the current transpose: octave in bits 6:4 counted
    // from one below the clamped pitch, semitone nibble in bits 3:0.
    function automatic logic [6:0] predict_key_code(input logic [6:0] note);
        int shift;
        int pitch;
        int below;
        int octave;
        logic [2:0] oct3;
        shift = transpose_setting;
        pitch = int'(note) + shift;
        if (pitch < 0) begin
            pitch = 0;
        end
        if (pitch > 127) begin
            pitch = 127;
        end
        below  = (pitch > 0) ? pitch - 1 : 0;
        octave = below / 12 - 1;
        if (octave < 0) begin
            octave = 0;
        end
        if (octave > 7) begin
            octave = 7;
        end
        oct3 = octave[2:0];
        return {oct3, NIBBLE_OF_SEMITONE[below % 12]};
    endfunction

    function automatic void note_action(input pva_action_t act, input int v,
                                        input logic [6:0] code);
        pva_out_t r;
        r.action      = act;
        r.voice_index = v[2:0];
        r.key_code    = code;
        r.last        = 1'b0;
        batch_actions.push_back(r);
    endfunction

    // Key off every voice playing the note, or mark it sustained while the pedal is down.
    function automatic void release_note(input logic [6:0] note);
        for (int i = 0; i < VOICES; i++) begin
            if (voice_on[i] && voice_note[i] == note) begin
                if (pedal_is_down) begin
                    voice_sustained[i] = 1'b1;
                end else begin
                    note_action(ACT_KEY_OFF, i, '0);
                    voice_on[i]        = 1'b0;
                    voice_sustained[i] = 1'b0;
                end
            end
        end
    endfunction

    // Retrigger a voice on the same note, else take the lowest free voice, else steal the
    // voice with the largest age distance (lowest index on a tie).
    function automatic void start_note(input logic [6:0] note);
        int v;
        logic [AGE_BITS-1:0] widest;
        logic [AGE_BITS-1:0] spread;
        v = -1;
        for (int i = 0; i < VOICES && v < 0; i++) begin
            if (voice_on[i] && voice_note[i] == note) begin
                v = i;
                note_action(ACT_RETRIG, i, '0);
                voice_stamp[i] = age_now;
                age_now++;
            end
        end
        for (int i = 0; i < VOICES && v < 0; i++) begin
            if (!voice_on[i]) begin
                v = i;
            end
        end
        if (v < 0) begin
            widest = age_now - voice_stamp[0];
            v = 0;
            for (int i = 1; i < VOICES; i++) begin
                spread = age_now - voice_stamp[i];
                if (spread > widest) begin
                    widest = spread;
                    v = i;
                end
            end
            note_action(ACT_STEAL, v, '0);
        end
        voice_on[v]        = 1'b1;
        voice_sustained[v] = 1'b0;
        voice_note[v]      = note;
        voice_stamp[v]     = age_now;
        age_now++;
        note_action(ACT_KEY_ON, v, predict_key_code(note));
    endfunction

    // Only the sustain controller acts; lifting a down pedal frees every sustained voice.
    function automatic void pedal_change(input logic [6:0] ctl, input logic [6:0] value);
        logic down;
        if (ctl == CTL_SUSTAIN) begin
            down = (value >= 7'd64);
            if (pedal_is_down && !down) begin
                for (int i = 0; i < VOICES; i++) begin
                    if (voice_on[i] && voice_sustained[i]) begin
                        note_action(ACT_KEY_OFF, i, '0);
                        voice_on[i]        = 1'b0;
                        voice_sustained[i] = 1'b0;
                    end
                end
            end
            pedal_is_down = down;
        end
    endfunction

    function automatic void allocate_voices(input pva_in_t w);
        batch_actions.delete();
        case (w.req_type)
            REQ_NOTE_ON: begin
                if (w.velocity_or_value == 7'd0) begin
                    release_note(w.note_or_control);
                end else begin
                    start_note(w.note_or_control);
                end
            end
            REQ_NOTE_OFF: begin
                release_note(w.note_or_control);
            end
            REQ_CONTROL: begin
                pedal_change(w.note_or_control, w.velocity_or_value);
            end
            default: begin
            end
        endcase
        if (batch_actions.size() != 0) begin
            batch_actions[batch_actions.size() - 1].last = 1'b1;
        end
        foreach (batch_actions[k]) begin
            voice_actions_due.push_back(batch_actions[k]);
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------------------

    // The receiver wanders between streaming, coin flips, sparse acceptance and a rotating
    // mask. A long hold-off, when asked for by a test, overrides all of them.
    always @(posedge aclk) begin : result_stalls
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        logic [15:0] ready_mask;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            mode_left = 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_served != hold_asks) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(32, 256);
                ready_mask = 16'($urandom) | 16'h0001;
            end
            mode_left--;
            case (rx_mode)
                RX_STREAM: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    m_ready    <= ready_mask[0];
                    ready_mask = {ready_mask[0], ready_mask[15:1]};
                end
            endcase
        end
    end

    // Every accepted result word is matched against the oldest owed action.
    always @(posedge aclk) begin : check_words
        pva_out_t due;
        if (aresetn && m_valid && m_ready) begin
            if (voice_actions_due.size() == 0) begin
                $error("result word with nothing owed: action %0d voice %0d key_code %0d",
                       m_word.action, m_word.voice_index, m_word.key_code);
                bad_count++;
            end else begin
                due = voice_actions_due.pop_front();
                if (m_word.action !== due.action) begin
                    $error("action: expected %0d, got %0d", due.action, m_word.action);
                    bad_count++;
                end
                if (m_word.voice_index !== due.voice_index) begin
                    $error("voice_index: expected %0d, got %0d",
                           due.voice_index, m_word.voice_index);
                    bad_count++;
                end
                if (m_word.key_code !== due.key_code) begin
                    $error("key_code: expected 0x%02h, got 0x%02h", due.key_code, m_word.key_code);
                    bad_count++;
                end
                if (m_word.last !== due.last) begin
                    $error("last: expected %0d, got %0d", due.last, m_word.last);
                    bad_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------------------

    function automatic pva_in_t make_word(input pva_req_t kind, input int field_a,
                                          input int field_b);
        pva_in_t w;
        w.req_type          = kind;
        w.note_or_control   = 7'(field_a);
        w.velocity_or_value = 7'(field_b);
        return w;
    endfunction

    // Offer one word and wait for its handshake. Outside eager stretches the sender runs in
    // random bursts separated by random gaps. Valid is left high on return, so a word that
    // follows at once keeps valid up without a dip.
    task automatic send_word(input pva_in_t w);
        int unsigned gap;
        if (!sender_eager) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                case ($urandom_range(0, 3))
                    0:       gap = 0;
                    1, 2:    gap = $urandom_range(1, 8);
                    default: gap = $urandom_range(9, 40);
                endcase
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        allocate_voices(w);
    endtask

    // Stop offering, wait until every owed action has come back, then let the block finish
    // any word that produced nothing.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (voice_actions_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic write_transpose(input int semitones);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 7'(semitones);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        transpose_setting = 7'(semitones);
    endtask

    // Random MIDI traffic. Note numbers cluster around a moving base so that retriggers and
    // steals are common, and most note offs name a note that is actually sounding.
    function automatic pva_in_t random_event();
        pva_in_t w;
        int      pick;
        int      note;
        int      live[$];
        pick = $urandom_range(0, 99);
        note = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 127)
                                             : note_base + $urandom_range(0, 15);
        if (pick < 45) begin
            w = make_word(REQ_NOTE_ON, note,
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 127));
        end else if (pick < 75) begin
            for (int i = 0; i < VOICES; i++) begin
                if (voice_on[i]) begin
                    live.push_back(voice_note[i]);
                end
            end
            if (live.size() != 0 && $urandom_range(0, 4) != 0) begin
                note = live[$urandom_range(0, live.size() - 1)];
            end
            if ($urandom_range(0, 4) == 0) begin
                w = make_word(REQ_NOTE_ON, note, 0);
            end else begin
                w = make_word(REQ_NOTE_OFF, note, $urandom_range(0, 127));
            end
        end else if (pick < 95) begin
            w = make_word(REQ_CONTROL,
                          ($urandom_range(0, 9) < 7) ? int'(CTL_SUSTAIN) : $urandom_range(0, 127),
                          $urandom_range(0, 127));
        end else begin
            w = make_word(REQ_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Field extremes, retrigger, zero velocity, unmatched note off, stealing the oldest
    // voice, pedal hold and release, foreign controllers and the unused request type.
    task automatic test_directed();
        send_word(make_word(REQ_NOTE_ON, 0, 127));
        send_word(make_word(REQ_NOTE_ON, 127, 1));
        send_word(make_word(REQ_NOTE_ON, 0, 64));
        send_word(make_word(REQ_NOTE_ON, 0, 0));
        send_word(make_word(REQ_NOTE_OFF, 5, 0));
        // Seven more notes fill the table; the next one must steal the oldest voice.
        for (int n = 60; n <= 66; n++) begin
            send_word(make_word(REQ_NOTE_ON, n, 100));
        end
        send_word(make_word(REQ_NOTE_ON, 70, 85));
        send_word(make_word(REQ_CONTROL, CTL_SUSTAIN, 127));
        send_word(make_word(REQ_NOTE_OFF, 60, 0));
        send_word(make_word(REQ_NOTE_ON, 61, 0));
        send_word(make_word(REQ_CONTROL, CTL_SUSTAIN, 64));
        send_word(make_word(REQ_CONTROL, CTL_SUSTAIN, 63));
        send_word(make_word(REQ_CONTROL, CTL_SUSTAIN, 0));
        send_word(make_word(REQ_CONTROL, 1, 100));
        send_word(make_word(REQ_UNUSED, 127, 127));
        send_word(make_word(REQ_NOTE_OFF, 127, 127));
        send_word(make_word(REQ_NOTE_OFF, 70, 127));
    endtask

    // Key code clamping at both ends of the note range, under transposes of -48, 48 and -1.
    task automatic test_transpose();
        int shifts[3] = '{-48, 48, -1};
        foreach (shifts[k]) begin
            settle_block();
            write_transpose(shifts[k]);
            send_word(make_word(REQ_NOTE_ON, 0, $urandom_range(1, 127)));
            send_word(make_word(REQ_NOTE_ON, 1, $urandom_range(1, 127)));
            send_word(make_word(REQ_NOTE_ON, 126, $urandom_range(1, 127)));
            send_word(make_word(REQ_NOTE_ON, 127, $urandom_range(1, 127)));
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering words
    // back to back, so the block fills and must stall its input.
    task automatic test_backpressure();
        hold_asks++;
        sender_eager = 1'b1;
        repeat (PRESSURE_WORDS) send_word(random_event());
        sender_eager = 1'b0;
        settle_block();
    endtask

    // Random traffic in phases, each under its own transpose and note neighborhood.
    task automatic test_random_traffic();
        int shift;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_block();
            case (phase)
                1:       shift = 48;
                3:       shift = -48;
                4:       shift = 0;
                default: shift = int'($urandom_range(0, 96)) - 48;
            endcase
            write_transpose(shift);
            note_base = $urandom_range(0, 112);
            repeat (PHASE_WORDS) send_word(random_event());
        end
    endtask

    initial begin
        reset_voice_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_transpose();
        test_backpressure();
        test_random_traffic();

        settle_block();
        if (bad_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/pva_pkg.sv
rtl/pva_ram.sv
rtl/pva_seq.sv
rtl/poly_voice_allocator.sv
dv/poly_voice_allocator_test.sv
